FILE: rtl/atbg_pkg.sv
// Shared types, constants and codes for the airtime token bucket gate.
package atbg_pkg;

   localparam int unsigned SourceSlotsDefault = 8;
   localparam logic [7:0] RelayMinLength = 8'd12;

   localparam logic [31:0] GlobalCapacityReset = 32'd360000;
   localparam logic [15:0] GlobalRateReset = 16'd100;
   localparam logic [31:0] SourceCapacityReset = 32'd100000;
   localparam logic [15:0] SourceRateReset = 16'd20;
   localparam logic [31:0] LowWatermarkReset = 32'd50000;
   localparam logic [7:0] TypeOffsetReset = 8'd3;
   localparam logic [7:0] RelayMaskReset = 8'd1;

   localparam logic [2:0] RegGlobalCapacity = 3'd0;
   localparam logic [2:0] RegGlobalRate = 3'd1;
   localparam logic [2:0] RegSourceCapacity = 3'd2;
   localparam logic [2:0] RegSourceRate = 3'd3;
   localparam logic [2:0] RegLowWatermark = 3'd4;
   localparam logic [2:0] RegTypeOffset = 3'd5;
   localparam logic [2:0] RegRelayMask = 3'd6;

   localparam logic [1:0] ClassControl = 2'd0;
   localparam logic [1:0] ClassChat = 2'd1;
   localparam logic [1:0] ClassMetrics = 2'd2;
   localparam logic [1:0] ClassBulk = 2'd3;

   localparam logic [1:0] CauseNone = 2'd0;
   localparam logic [1:0] CauseGlobal = 2'd1;
   localparam logic [1:0] CauseSource = 2'd2;

   typedef struct packed {
      logic [7:0] frame_length;
      logic [7:0] type_byte;
      logic [7:0] flags_byte;
      logic [31:0] source_id;
      logic [31:0] airtime_us;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic accepted;
      logic [1:0] pkt_class;
      logic [1:0] drop_cause;
      logic tokens_low;
      logic [31:0] global_tokens;
   } rsp_type;

   typedef struct packed {
      logic [31:0] global_capacity;
      logic [15:0] global_refill_rate;
      logic [31:0] source_capacity;
      logic [15:0] source_refill_rate;
      logic [31:0] low_watermark;
      logic [7:0] type_offset;
      logic [7:0] relay_mask;
   } cfg_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load;      // classify held request, clear flags
      logic global_op; // refill + consume global
      logic scan;      // examine one source slot
      logic source_op; // refill + check chosen slot
      logic finish;    // drop counting, emit result
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic is_control;
      logic global_short;
      logic relay;
      logic scan_last;
   } status_type;

   function automatic logic [1:0] classify(input logic [7:0] t);
      logic [1:0] c;
      case (t)
         8'd2, 8'd3, 8'd4, 8'd5, 8'd7: c = ClassControl;
         8'd1: c = ClassChat;
         8'd6: c = ClassMetrics;
         default: c = ClassBulk;
      endcase
      return c;
   endfunction

   // min(level + add, cap) without overflow
   function automatic logic [31:0] sat_add(input logic [31:0] level,
                                           input logic [47:0] add,
                                           input logic [31:0] cap);
      logic [48:0] sum;
      sum = {17'd0, level} + {1'b0, add};
      return (sum > {17'd0, cap}) ? cap : sum[31:0];
   endfunction

endpackage

FILE: rtl/atbg_ctrl.sv
// Sequencer for the airtime gate: steps one request through its phases.
module atbg_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  atbg_pkg::status_type  status,
   output atbg_pkg::cmd_type     cmd
);
   import atbg_pkg::*;

   typedef enum logic [2:0] {
      IDLE, CLASSIFY, GLOBAL, SCAN, SOURCE, FINISH
   } state_type;

   state_type state_ff, state_in;
   cmd_type cmd_ff, cmd_in;

   always_comb begin
      state_in = state_ff;
      cmd_in = '0;
      case (state_ff)
         IDLE: begin
            if (start && !busy) begin
               cmd_in.load = 1'b1;
               state_in = CLASSIFY;
            end
         end
         CLASSIFY: begin
            // load runs in this cycle; the class is ready in the next one
            state_in = GLOBAL;
         end
         GLOBAL: begin
            if (status.is_control) begin
               state_in = FINISH;
            end else begin
               cmd_in.global_op = 1'b1;
               state_in = FINISH;
            end
         end
         FINISH: begin
            if (!status.is_control && !status.global_short && status.relay) begin
               state_in = SCAN;
            end else begin
               cmd_in.finish = 1'b1;
               state_in = IDLE;
            end
         end
         SCAN: begin
            cmd_in.scan = 1'b1;
            if (status.scan_last) begin
               state_in = SOURCE;
            end
         end
         SOURCE: begin
            cmd_in.source_op = 1'b1;
            state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         cmd_ff <= '0;
      end else begin
         state_ff <= state_in;
         cmd_ff <= cmd_in;
      end
   end

   // SOURCE issues source_op, whose cycle also completes the result
   assign cmd = cmd_ff;
   assign busy = (state_ff != IDLE) || (cmd_ff != '0);
endmodule

FILE: rtl/atbg_dp.sv
// Datapath for the airtime gate: buckets, source slots and counters.
module atbg_dp #(
   parameter int unsigned SOURCE_SLOTS = atbg_pkg::SourceSlotsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  atbg_pkg::req_type     req_payload,
   input  logic                  req_take,
   input  atbg_pkg::cfg_type     cfg,
   input  atbg_pkg::cmd_type     cmd,
   output atbg_pkg::status_type  status,
   output logic                  rsp_strobe,
   output atbg_pkg::rsp_type     rsp_payload
);
   import atbg_pkg::*;

   localparam int unsigned SlotBits = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
   localparam logic [SlotBits-1:0] LastSlot = SlotBits'(SOURCE_SLOTS - 1);

   req_type req_ff;
   logic [1:0] cls_ff;
   logic [31:0] g_level_ff, g_last_ff;
   logic short_ff, low_ff, relay_ff;
   logic [31:0] node_ff [SOURCE_SLOTS];
   logic [31:0] s_level_ff [SOURCE_SLOTS];
   logic [31:0] s_last_ff [SOURCE_SLOTS];
   logic [31:0] drop_count_ff [4];
   logic [31:0] low_count_ff;
   logic [SlotBits-1:0] idx_ff;
   logic match_ff, free_ff;
   logic [SlotBits-1:0] match_idx_ff, free_idx_ff, lru_idx_ff;
   logic [31:0] lru_ts_ff;
   logic strobe_ff;
   rsp_type rsp_ff;

   // global refill + consume, kept in one stage
   logic [31:0] g_elapsed, g_refilled, g_after;
   logic [47:0] g_add;
   logic g_short;
   always_comb begin
      g_elapsed = req_ff.now_ms - g_last_ff;
      g_add = g_elapsed * cfg.global_refill_rate;
      g_refilled = (req_ff.now_ms == g_last_ff) ? g_level_ff
                 : sat_add(g_level_ff, g_add, cfg.global_capacity);
      g_short = g_refilled < req_ff.airtime_us;
      g_after = g_refilled - req_ff.airtime_us;
   end

   // chosen slot and its refill
   logic [SlotBits-1:0] pick;
   logic fresh;
   logic [31:0] s_level, s_last, s_refilled, s_elapsed;
   logic [47:0] s_add;
   logic s_short;
   always_comb begin
      pick = match_ff ? match_idx_ff : (free_ff ? free_idx_ff : lru_idx_ff);
      fresh = !match_ff;
      s_level = fresh ? cfg.source_capacity : s_level_ff[pick];
      s_last = fresh ? req_ff.now_ms : s_last_ff[pick];
      s_elapsed = req_ff.now_ms - s_last;
      s_add = s_elapsed * cfg.source_refill_rate;
      s_refilled = (req_ff.now_ms == s_last) ? s_level
                 : sat_add(s_level, s_add, cfg.source_capacity);
      s_short = s_refilled < req_ff.airtime_us;
   end

   always_comb begin
      status.is_control = (cls_ff == ClassControl);
      // the global verdict is live while global_op runs
      status.global_short = cmd.global_op ? g_short : short_ff;
      status.relay = relay_ff;
      status.scan_last = (idx_ff == LastSlot) || (match_ff);
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_payload;
      end
      if (cmd.load) begin
         cls_ff <= classify((req_ff.frame_length > cfg.type_offset)
                            ? req_ff.type_byte : 8'd0);
         short_ff <= 1'b0;
         low_ff <= 1'b0;
         relay_ff <= (req_ff.frame_length > RelayMinLength)
                   && ((req_ff.flags_byte & cfg.relay_mask) != 8'd0)
                   && (req_ff.source_id != 32'd0);
         idx_ff <= '0;
         match_ff <= 1'b0;
         free_ff <= 1'b0;
         lru_idx_ff <= '0;
         lru_ts_ff <= s_last_ff[0];
      end
      if (cmd.global_op) begin
         short_ff <= g_short;
         if (!g_short) begin
            low_ff <= g_after < cfg.low_watermark;
         end
      end
      if (cmd.scan && !match_ff) begin
         // walk one slot: match ends the walk, else track first free and oldest
         if (node_ff[idx_ff] == req_ff.source_id) begin
            match_ff <= 1'b1;
            match_idx_ff <= idx_ff;
         end else begin
            if (node_ff[idx_ff] == 32'd0 && !free_ff) begin
               free_ff <= 1'b1;
               free_idx_ff <= idx_ff;
            end
            if (s_last_ff[idx_ff] < lru_ts_ff) begin
               lru_ts_ff <= s_last_ff[idx_ff];
               lru_idx_ff <= idx_ff;
            end
         end
         if (idx_ff != LastSlot) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
      rsp_ff.pkt_class <= cls_ff;
      rsp_ff.tokens_low <= low_ff;
      if (cmd.source_op) begin
         rsp_ff.accepted <= !s_short;
         rsp_ff.drop_cause <= s_short ? CauseSource : CauseNone;
         rsp_ff.global_tokens <= s_short
            ? sat_add(g_level_ff, {16'd0, req_ff.airtime_us}, cfg.global_capacity)
            : g_level_ff;
      end else begin
         rsp_ff.accepted <= !short_ff;
         rsp_ff.drop_cause <= short_ff ? CauseGlobal : CauseNone;
         rsp_ff.global_tokens <= g_level_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_level_ff <= GlobalCapacityReset;
         g_last_ff <= '0;
         low_count_ff <= '0;
         strobe_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            drop_count_ff[i] <= '0;
         end
         for (int i = 0; i < SOURCE_SLOTS; i++) begin
            node_ff[i] <= '0;
            s_level_ff[i] <= '0;
            s_last_ff[i] <= '0;
         end
      end else begin
         strobe_ff <= cmd.finish || cmd.source_op;
         if (cmd.global_op) begin
            g_last_ff <= req_ff.now_ms;
            g_level_ff <= g_short ? g_refilled : g_after;
            if (!g_short && (g_after < cfg.low_watermark)) begin
               low_count_ff <= low_count_ff + 32'd1;
            end
         end
         if (cmd.finish && short_ff) begin
            drop_count_ff[cls_ff] <= drop_count_ff[cls_ff] + 32'd1;
         end
         if (cmd.source_op) begin
            node_ff[pick] <= req_ff.source_id;
            s_last_ff[pick] <= req_ff.now_ms;
            if (s_short) begin
               s_level_ff[pick] <= s_refilled;
               g_level_ff <= sat_add(g_level_ff, {16'd0, req_ff.airtime_us},
                                     cfg.global_capacity);
               drop_count_ff[cls_ff] <= drop_count_ff[cls_ff] + 32'd1;
            end else begin
               s_level_ff[pick] <= s_refilled - req_ff.airtime_us;
            end
         end
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_payload = rsp_ff;
endmodule

FILE: rtl/airtime_token_bucket_gate_unit.sv
// Top level of the airtime token bucket admission gate.
// Flow: the accepting edge enters CLASSIFY (load), then GLOBAL and FINISH;
// relayed frames then walk the slots (SCAN) and update one (SOURCE).
// Throughput: one transaction at a time; busy drops in the result cycle.
// The slot walk sets the relay path length.
// Reset (synchronous) restores config registers, buckets, slots and counters.
module airtime_token_bucket_gate_unit #(
   parameter int unsigned SOURCE_SLOTS = atbg_pkg::SourceSlotsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  atbg_pkg::req_type   req_payload,
   output logic                rsp_valid,
   output atbg_pkg::rsp_type   rsp_payload,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_data
);
   import atbg_pkg::*;

   cfg_type cfg_ff;
   cmd_type cmd;
   status_type status;
   logic req_take;

   assign req_take = start && !busy;
   assign csr_ready = 1'b1;

   // register file: write any index, drop unknown ones
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.global_capacity <= GlobalCapacityReset;
         cfg_ff.global_refill_rate <= GlobalRateReset;
         cfg_ff.source_capacity <= SourceCapacityReset;
         cfg_ff.source_refill_rate <= SourceRateReset;
         cfg_ff.low_watermark <= LowWatermarkReset;
         cfg_ff.type_offset <= TypeOffsetReset;
         cfg_ff.relay_mask <= RelayMaskReset;
      end else if (csr_valid) begin
         case (csr_index)
            RegGlobalCapacity: cfg_ff.global_capacity <= csr_data;
            RegGlobalRate: cfg_ff.global_refill_rate <= csr_data[15:0];
            RegSourceCapacity: cfg_ff.source_capacity <= csr_data;
            RegSourceRate: cfg_ff.source_refill_rate <= csr_data[15:0];
            RegLowWatermark: cfg_ff.low_watermark <= csr_data;
            RegTypeOffset: cfg_ff.type_offset <= csr_data[7:0];
            RegRelayMask: cfg_ff.relay_mask <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   atbg_ctrl u_ctrl (
      .clock (clock), .reset (reset), .start (start), .busy (busy),
      .status (status), .cmd (cmd)
   );

   atbg_dp #(.SOURCE_SLOTS(SOURCE_SLOTS)) u_dp (
      .clock (clock), .reset (reset), .req_payload (req_payload),
      .req_take (req_take), .cfg (cfg_ff), .cmd (cmd), .status (status),
      .rsp_strobe (rsp_valid), .rsp_payload (rsp_payload)
   );

   // one command at a time from the sequencer
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd)) else $error("multiple commands");
   // busy is raised once a transaction is taken
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> busy) else $error("busy not raised");
   // a result never appears without an active transaction before it
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("stray result");
endmodule
